@@ src/afifo_pkg.sv @@
// ----------------------------------------------------------------------------
// afifo_pkg
// Shared sizes, codes and types of the audio frame FIFO.
// ----------------------------------------------------------------------------
package afifo_pkg;

   // Storage geometry
   localparam int DEPTH        = 256;
   localparam int MAX_CHANNELS = 8;
   localparam int SLOT_W       = $clog2(DEPTH);

   // Field widths
   localparam int SAMPLE_W = 32;
   localparam int CAP_W    = 9;
   localparam int CH_W     = 4;
   localparam int EVENT_W  = 32;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_CAPACITY = 1'b0;
   localparam logic CSR_IDX_CHANNELS = 1'b1;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(256);
   localparam logic [CH_W-1:0]  CHANNELS_RESET = CH_W'(2);

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_DROPPED  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_UNDERRUN = 2'd2;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef sample_type [MAX_CHANNELS-1:0] frame_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;   // capture the incoming word
      logic exec;   // apply the captured word to pointers, counters and storage
   } cmd_type;

endpackage

@@ src/afifo_ram.sv @@
// ----------------------------------------------------------------------------
// afifo_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module afifo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/afifo_ctrl.sv @@
// ----------------------------------------------------------------------------
// afifo_ctrl
// Sequencer: take a word, execute it, present the result for one cycle.
// ----------------------------------------------------------------------------
module afifo_ctrl
   import afifo_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_strobe,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      strobe_ff, strobe_in;
   logic      accept;

   assign accept = start && !busy_ff;

   always_comb begin
      state_in  = state_ff;
      busy_in   = busy_ff;
      strobe_in = 1'b0;
      case (state_ff)
         ST_IDLE, ST_RESP: begin
            if (accept) begin
               state_in = ST_EXEC;
               busy_in  = 1'b1;
            end else begin
               state_in = ST_IDLE;
               busy_in  = 1'b0;
            end
         end
         ST_EXEC: begin
            state_in  = ST_RESP;
            busy_in   = 1'b0;
            strobe_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;
   assign cmd.load   = accept;
   assign cmd.exec   = (state_ff == ST_EXEC);

`ifndef NO_ASSERTIONS
   // each accepted word is executed in the following cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> cmd.exec)
      else $error("accepted word not executed");

   // a result follows every execute cycle, and only then
   a_exec_strobe: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_strobe)
      else $error("execute without result");

   a_busy_exec: assert property (@(posedge clock) disable iff (reset)
      busy == cmd.exec)
      else $error("busy out of step with execute state");
`endif

endmodule

@@ src/afifo_dp.sv @@
// ----------------------------------------------------------------------------
// afifo_dp
// Datapath: frame storage lanes, ring pointers, frame count, event counters.
// ----------------------------------------------------------------------------
module afifo_dp
   import afifo_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic [CAP_W-1:0]    cfg_capacity,
   input  logic [CH_W-1:0]     cfg_channels,
   input  logic [ACTION_W-1:0] req_action,
   input  frame_type           req_frame,
   output frame_type           rsp_frame,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [CAP_W-1:0]    rsp_frames_stored,
   output logic [EVENT_W-1:0]  rsp_overrun_total,
   output logic [EVENT_W-1:0]  rsp_underrun_total
);

   logic [ACTION_W-1:0]     action_ff;
   frame_type               frame_ff;
   logic [SLOT_W-1:0]       read_slot_ff, read_slot_in;
   logic [SLOT_W-1:0]       write_slot_ff, write_slot_in;
   logic [CAP_W-1:0]        count_ff, count_in;
   logic [EVENT_W-1:0]      overrun_ff, overrun_in;
   logic [EVENT_W-1:0]      underrun_ff, underrun_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [MAX_CHANNELS-1:0] lane_mask_ff, lane_mask_in;

   logic [CAP_W-1:0]        cap_eff;
   logic [CH_W-1:0]         ch_eff;
   logic [MAX_CHANNELS-1:0] lane_used;
   logic                    full;
   logic                    is_push, is_pop;
   logic                    pop_ok;
   logic [SLOT_W-1:0]       read_next, write_next;
   frame_type               ram_rd_data;

   // Clamp configuration into its working range
   always_comb begin
      cap_eff = cfg_capacity;
      if (cfg_capacity == '0) begin
         cap_eff = CAP_W'(1);
      end else if (32'(cfg_capacity) > 32'(DEPTH)) begin
         cap_eff = CAP_W'(DEPTH);
      end
      ch_eff = cfg_channels;
      if (cfg_channels == '0) begin
         ch_eff = CH_W'(1);
      end else if (32'(cfg_channels) > 32'(MAX_CHANNELS)) begin
         ch_eff = CH_W'(MAX_CHANNELS);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         lane_used[i] = (32'(i) < 32'(ch_eff));
      end
   end

   // Slot advance wraps at the capacity, or past it after capacity was lowered
   function automatic logic [SLOT_W-1:0] advance(input logic [SLOT_W-1:0] slot,
                                                 input logic [CAP_W-1:0]  cap);
      logic [SLOT_W:0] n;
      n = {1'b0, slot} + (SLOT_W+1)'(1);
      return (32'(n) >= 32'(cap)) ? '0 : n[SLOT_W-1:0];
   endfunction

   function automatic logic [EVENT_W-1:0] sat_inc(input logic [EVENT_W-1:0] v);
      return (v == '1) ? v : v + EVENT_W'(1);
   endfunction

   assign read_next  = advance(read_slot_ff, cap_eff);
   assign write_next = advance(write_slot_ff, cap_eff);
   assign full       = (count_ff >= cap_eff);
   assign is_push    = cmd.exec && (action_ff == ACT_PUSH);
   assign is_pop     = cmd.exec && (action_ff == ACT_POP);
   assign pop_ok     = is_pop && (count_ff != '0);

   always_comb begin
      read_slot_in  = read_slot_ff;
      write_slot_in = write_slot_ff;
      count_in      = count_ff;
      overrun_in    = overrun_ff;
      underrun_in   = underrun_ff;
      status_in     = STAT_OK;
      lane_mask_in  = '0;
      case (action_ff)
         ACT_PUSH: begin
            if (full) begin
               read_slot_in = read_next;
               overrun_in   = sat_inc(overrun_ff);
               status_in    = STAT_DROPPED;
            end else begin
               count_in = count_ff + CAP_W'(1);
            end
            write_slot_in = write_next;
         end
         ACT_POP: begin
            if (count_ff == '0) begin
               underrun_in = sat_inc(underrun_ff);
               status_in   = STAT_UNDERRUN;
            end else begin
               lane_mask_in = lane_used;
               read_slot_in = read_next;
               count_in     = count_ff - CAP_W'(1);
            end
         end
         ACT_FLUSH: begin
            read_slot_in  = '0;
            write_slot_in = '0;
            count_in      = '0;
            overrun_in    = '0;
            underrun_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_slot_ff  <= '0;
         write_slot_ff <= '0;
         count_ff      <= '0;
         overrun_ff    <= '0;
         underrun_ff   <= '0;
         status_ff     <= STAT_OK;
         lane_mask_ff  <= '0;
      end else if (cmd.exec) begin
         read_slot_ff  <= read_slot_in;
         write_slot_ff <= write_slot_in;
         count_ff      <= count_in;
         overrun_ff    <= overrun_in;
         underrun_ff   <= underrun_in;
         status_ff     <= status_in;
         lane_mask_ff  <= lane_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         frame_ff  <= req_frame;
      end
   end

   // One RAM per channel lane, addressed by frame slot
   for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
      afifo_ram #(
         .WIDTH (SAMPLE_W),
         .DEPTH (DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (is_push && lane_used[g]),
         .wr_addr (write_slot_ff),
         .wr_data (frame_ff[g]),
         .rd_en   (pop_ok),
         .rd_addr (read_slot_ff),
         .rd_data (ram_rd_data[g])
      );

      assign rsp_frame[g] = ram_rd_data[g] & {SAMPLE_W{lane_mask_ff[g]}};
   end

   assign rsp_status         = status_ff;
   assign rsp_frames_stored  = count_ff;
   assign rsp_overrun_total  = overrun_ff;
   assign rsp_underrun_total = underrun_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(DEPTH))
      else $error("frame count above storage depth");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && action_ff == ACT_FLUSH) |=>
         (count_ff == '0 && overrun_ff == '0 && underrun_ff == '0))
      else $error("flush left state behind");

   a_drop_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (is_push && full) |=> (count_ff == $past(count_ff) && status_ff == STAT_DROPPED))
      else $error("drop-oldest push changed the frame count");
`endif

endmodule

@@ src/audio_frame_fifo_drop_oldest.sv @@
// ----------------------------------------------------------------------------
// audio_frame_fifo_drop_oldest
// Audio frame FIFO that drops the oldest frame on overrun and returns silence
// on underrun, with saturating event counters and an APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_action and the req_sample_* words and raise
//   start; the word is taken at the edge where start is high and busy is low.
//   Actions: push one frame, pop one frame, flush pointers, count, counters.
//   Result channel: rsp_strobe marks exactly one cycle carrying the popped
//   samples (zero outside a good pop and above the channel count), status,
//   frames stored and both event totals. The receiver cannot stall; sample
//   the result in the strobe cycle.
//   Timing: the cycle after the accepting edge executes the word; the strobe
//   is high in the next cycle, and the result is taken at the edge that
//   ends the strobe cycle. busy is high for the execute cycle only, so a
//   new word can be taken in the strobe cycle. The result comes from the
//   registered read of the per-lane frame RAMs, made in the execute cycle.
//   Reset: pointers, frame count and counters clear; capacity returns to 256
//   frames and channels in use to 2. Frame RAM is not cleared.
//   Registers (write only when idle): 0x0 capacity_frames, 0x4
//   channels_in_use; 0 acts as 1, values above the limit act as the limit.
// ----------------------------------------------------------------------------
module audio_frame_fifo_drop_oldest
   import afifo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [SAMPLE_W-1:0]   req_sample_0,
   input  logic [SAMPLE_W-1:0]   req_sample_1,
   input  logic [SAMPLE_W-1:0]   req_sample_2,
   input  logic [SAMPLE_W-1:0]   req_sample_3,
   input  logic [SAMPLE_W-1:0]   req_sample_4,
   input  logic [SAMPLE_W-1:0]   req_sample_5,
   input  logic [SAMPLE_W-1:0]   req_sample_6,
   input  logic [SAMPLE_W-1:0]   req_sample_7,
   // result channel
   output logic                  rsp_strobe,
   output logic [SAMPLE_W-1:0]   rsp_out_sample_0,
   output logic [SAMPLE_W-1:0]   rsp_out_sample_1,
   output logic [SAMPLE_W-1:0]   rsp_out_sample_2,
   output logic [SAMPLE_W-1:0]   rsp_out_sample_3,
   output logic [SAMPLE_W-1:0]   rsp_out_sample_4,
   output logic [SAMPLE_W-1:0]   rsp_out_sample_5,
   output logic [SAMPLE_W-1:0]   rsp_out_sample_6,
   output logic [SAMPLE_W-1:0]   rsp_out_sample_7,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [CAP_W-1:0]      rsp_frames_stored,
   output logic [EVENT_W-1:0]    rsp_overrun_total,
   output logic [EVENT_W-1:0]    rsp_underrun_total,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cmd_type          cmd;
   frame_type        req_frame;
   frame_type        rsp_frame;
   logic [CAP_W-1:0] capacity_ff;
   logic [CH_W-1:0]  channels_ff;
   logic             csr_write;
   logic             csr_index;

   // Register port: zero wait states, index taken from the word address bit
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         channels_ff <= CHANNELS_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_IDX_CAPACITY) begin
            capacity_ff <= pwdata[CAP_W-1:0];
         end else begin
            channels_ff <= pwdata[CH_W-1:0];
         end
      end
   end

   // Read back the selected register, zero-extended
   always_comb begin
      if (csr_index == CSR_IDX_CHANNELS) begin
         prdata = CSR_DATA_W'(channels_ff);
      end else begin
         prdata = CSR_DATA_W'(capacity_ff);
      end
   end

   // Gather the sample ports into one frame
   assign req_frame[0] = req_sample_0;
   assign req_frame[1] = req_sample_1;
   assign req_frame[2] = req_sample_2;
   assign req_frame[3] = req_sample_3;
   assign req_frame[4] = req_sample_4;
   assign req_frame[5] = req_sample_5;
   assign req_frame[6] = req_sample_6;
   assign req_frame[7] = req_sample_7;

   // Sequencer: accept, execute, strobe
   afifo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // Storage, pointers and counters
   afifo_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .cfg_capacity       (capacity_ff),
      .cfg_channels       (channels_ff),
      .req_action         (req_action),
      .req_frame          (req_frame),
      .rsp_frame          (rsp_frame),
      .rsp_status         (rsp_status),
      .rsp_frames_stored  (rsp_frames_stored),
      .rsp_overrun_total  (rsp_overrun_total),
      .rsp_underrun_total (rsp_underrun_total)
   );

   // Spread the result frame onto its ports
   assign rsp_out_sample_0 = rsp_frame[0];
   assign rsp_out_sample_1 = rsp_frame[1];
   assign rsp_out_sample_2 = rsp_frame[2];
   assign rsp_out_sample_3 = rsp_frame[3];
   assign rsp_out_sample_4 = rsp_frame[4];
   assign rsp_out_sample_5 = rsp_frame[5];
   assign rsp_out_sample_6 = rsp_frame[6];
   assign rsp_out_sample_7 = rsp_frame[7];

endmodule

@@ sim/audio_frame_fifo_drop_oldest_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_frame_fifo_drop_oldest_test
// Self-checking bench for the drop-oldest audio frame FIFO. It drives command
// words through the start/busy handshake and predicts every result in a
// cycle-free model of the FIFO. It covers pushes into a full buffer, pops from
// an empty one, flushes, the unused action, and capacity and channel
// settings, including out-of-range values and changes with frames stored.
// ----------------------------------------------------------------------------
module audio_frame_fifo_drop_oldest_test;
   import afifo_pkg::*;

   // Action code the block ignores
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // Register byte addresses: register i sits at 4*i
   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR = CSR_ADDR_W'({CSR_IDX_CAPACITY, 2'b00});
   localparam logic [CSR_ADDR_W-1:0] CHANNELS_ADDR = CSR_ADDR_W'({CSR_IDX_CHANNELS, 2'b00});

   // Most mismatch lines printed; the rest are only counted
   localparam int PRINT_LIMIT = 40;

   // One command word as the block takes it
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      frame_type           samples;
   } fifo_word_type;

   // One result as the block reports it
   typedef struct packed {
      frame_type           lanes;
      logic [STATUS_W-1:0] status;
      logic [CAP_W-1:0]    stored;
      logic [EVENT_W-1:0]  overruns;
      logic [EVENT_W-1:0]  underruns;
   } fifo_reply_type;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   // Command channel
   logic                start      = 1'b0;
   logic                busy;
   logic [ACTION_W-1:0] req_action = ACT_PUSH;
   frame_type           req_frame  = '0;

   // Result channel
   logic                rsp_strobe;
   logic [SAMPLE_W-1:0] rsp_out_sample_0, rsp_out_sample_1, rsp_out_sample_2;
   logic [SAMPLE_W-1:0] rsp_out_sample_3, rsp_out_sample_4, rsp_out_sample_5;
   logic [SAMPLE_W-1:0] rsp_out_sample_6, rsp_out_sample_7;
   logic [STATUS_W-1:0] rsp_status;
   logic [CAP_W-1:0]    rsp_frames_stored;
   logic [EVENT_W-1:0]  rsp_overrun_total;
   logic [EVENT_W-1:0]  rsp_underrun_total;
   frame_type           seen_lanes;

   assign seen_lanes = {rsp_out_sample_7, rsp_out_sample_6, rsp_out_sample_5, rsp_out_sample_4,
                        rsp_out_sample_3, rsp_out_sample_2, rsp_out_sample_1, rsp_out_sample_0};

   // Register port
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   audio_frame_fifo_drop_oldest i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_sample_0       (req_frame[0]),
      .req_sample_1       (req_frame[1]),
      .req_sample_2       (req_frame[2]),
      .req_sample_3       (req_frame[3]),
      .req_sample_4       (req_frame[4]),
      .req_sample_5       (req_frame[5]),
      .req_sample_6       (req_frame[6]),
      .req_sample_7       (req_frame[7]),
      .rsp_strobe         (rsp_strobe),
      .rsp_out_sample_0   (rsp_out_sample_0),
      .rsp_out_sample_1   (rsp_out_sample_1),
      .rsp_out_sample_2   (rsp_out_sample_2),
      .rsp_out_sample_3   (rsp_out_sample_3),
      .rsp_out_sample_4   (rsp_out_sample_4),
      .rsp_out_sample_5   (rsp_out_sample_5),
      .rsp_out_sample_6   (rsp_out_sample_6),
      .rsp_out_sample_7   (rsp_out_sample_7),
      .rsp_status         (rsp_status),
      .rsp_frames_stored  (rsp_frames_stored),
      .rsp_overrun_total  (rsp_overrun_total),
      .rsp_underrun_total (rsp_underrun_total),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // -------------------------------------------------------------------------
   // FIFO prediction state, starting from the reset values
   // -------------------------------------------------------------------------
   logic [SAMPLE_W-1:0] frame_ram    [DEPTH][MAX_CHANNELS];
   bit                  lane_written [DEPTH][MAX_CHANNELS];
   logic [SLOT_W-1:0]   head_slot     = '0;   // oldest frame
   logic [SLOT_W-1:0]   tail_slot     = '0;   // next free slot
   logic [CAP_W-1:0]    held_frames   = '0;
   logic [EVENT_W-1:0]  overrun_seen  = '0;
   logic [EVENT_W-1:0]  underrun_seen = '0;
   logic [CAP_W-1:0]    capacity_setting = CAPACITY_RESET;
   logic [CH_W-1:0]     channel_setting  = CHANNELS_RESET;

   // Results predicted for accepted words, oldest first
   fifo_reply_type replies_due [$];

   int mismatch_count = 0;
   int push_count     = 0;
   int drop_count     = 0;
   int pop_count      = 0;
   int silent_count   = 0;
   int flush_count    = 0;
   int ignored_count  = 0;
   int setting_count  = 0;

   // 0 acts as 1, anything above the storage depth acts as the depth
   function automatic int capacity_in_force();
      if (capacity_setting == '0) return 1;
      if (int'(capacity_setting) > DEPTH) return DEPTH;
      return int'(capacity_setting);
   endfunction

   function automatic int channels_in_force();
      if (channel_setting == '0) return 1;
      if (int'(channel_setting) > MAX_CHANNELS) return MAX_CHANNELS;
      return int'(channel_setting);
   endfunction

   // Step a slot, wrapping at or past the capacity
   function automatic logic [SLOT_W-1:0] step_slot(logic [SLOT_W-1:0] slot, int cap);
      int n;
      n = int'(slot) + 1;
      return (n >= cap) ? '0 : SLOT_W'(n);
   endfunction

   function automatic logic [EVENT_W-1:0] bump_saturating(logic [EVENT_W-1:0] v);
      return (v == '1) ? v : v + EVENT_W'(1);
   endfunction

   // Apply one accepted word to the prediction state and return its result
   function automatic fifo_reply_type frame_fifo_update(fifo_word_type w);
      fifo_reply_type r;
      int cap;
      int ch;
      r   = '0;
      cap = capacity_in_force();
      ch  = channels_in_force();
      case (w.action)
         ACT_PUSH: begin
            push_count++;
            if (int'(held_frames) >= cap) begin
               head_slot    = step_slot(head_slot, cap);
               held_frames  = held_frames - CAP_W'(1);
               overrun_seen = bump_saturating(overrun_seen);
               r.status     = STAT_DROPPED;
               drop_count++;
            end
            for (int i = 0; i < ch; i++) begin
               frame_ram[tail_slot][i]    = w.samples[i];
               lane_written[tail_slot][i] = 1'b1;
            end
            tail_slot   = step_slot(tail_slot, cap);
            held_frames = held_frames + CAP_W'(1);
         end
         ACT_POP: begin
            pop_count++;
            if (held_frames == '0) begin
               underrun_seen = bump_saturating(underrun_seen);
               r.status      = STAT_UNDERRUN;
               silent_count++;
            end else begin
               for (int i = 0; i < ch; i++)
                  r.lanes[i] = frame_ram[head_slot][i];
               head_slot   = step_slot(head_slot, cap);
               held_frames = held_frames - CAP_W'(1);
            end
         end
         ACT_FLUSH: begin
            flush_count++;
            head_slot     = '0;
            tail_slot     = '0;
            held_frames   = '0;
            overrun_seen  = '0;
            underrun_seen = '0;
         end
         default: ignored_count++;
      endcase
      r.stored    = held_frames;
      r.overruns  = overrun_seen;
      r.underruns = underrun_seen;
      return r;
   endfunction

   // True when the next pop would read a lane that was never written
   function automatic bit pop_hits_unwritten();
      if (held_frames == '0) return 1'b0;
      for (int i = 0; i < channels_in_force(); i++)
         if (!lane_written[head_slot][i]) return 1'b1;
      return 1'b0;
   endfunction

   // Mostly random words, sometimes all zeros or all ones per lane
   function automatic frame_type random_frame();
      frame_type f;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         case ($urandom_range(0, 9))
            0:       f[i] = '0;
            1:       f[i] = '1;
            default: f[i] = $urandom;
         endcase
      end
      return f;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   // -------------------------------------------------------------------------
   // Result check: every strobe is matched against the oldest prediction
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      fifo_reply_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (replies_due.size() == 0) begin
            report_mismatch("result strobe with no word outstanding");
         end else begin
            want = replies_due.pop_front();
            for (int i = 0; i < MAX_CHANNELS; i++)
               if (seen_lanes[i] !== want.lanes[i])
                  report_mismatch($sformatf("out_sample_%0d got %h, want %h",
                                            i, seen_lanes[i], want.lanes[i]));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status got %0d, want %0d", rsp_status, want.status));
            if (rsp_frames_stored !== want.stored)
               report_mismatch($sformatf("frames_stored got %0d, want %0d",
                                         rsp_frames_stored, want.stored));
            if (rsp_overrun_total !== want.overruns)
               report_mismatch($sformatf("overrun_total got %0d, want %0d",
                                         rsp_overrun_total, want.overruns));
            if (rsp_underrun_total !== want.underruns)
               report_mismatch($sformatf("underrun_total got %0d, want %0d",
                                         rsp_underrun_total, want.underruns));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Command side
   // -------------------------------------------------------------------------

   // Offer one word and hold it until the block takes it. Leave start high so
   // a following word goes back to back; pausing or settling lowers it.
   task automatic send_word(input logic [ACTION_W-1:0] action, input frame_type samples);
      fifo_word_type w;
      w.action  = action;
      w.samples = samples;
      start      <= 1'b1;
      req_action <= action;
      req_frame  <= samples;
      do @(posedge clock); while (busy !== 1'b0);
      replies_due.push_back(frame_fifo_update(w));
   endtask

   // Drop start for a while and toggle noise on the idle command lines
   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) begin
         req_action <= ACTION_W'($urandom);
         req_frame  <= random_frame();
         @(posedge clock);
      end
   endtask

   // Hold off until every outstanding result has come, then let the pipe empty
   task automatic settle_fifo();
      start <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Register side: setup cycle, access cycle, then the idle cycle
   // -------------------------------------------------------------------------
   task automatic read_register(input logic [CSR_ADDR_W-1:0] addr,
                                output logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      data     = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write a register, mirror it in the prediction state and read it back
   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr, input int value);
      logic [CSR_DATA_W-1:0] readback;
      logic [CSR_DATA_W-1:0] want;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == CAPACITY_ADDR) begin
         capacity_setting = CAP_W'(value);
         want = CSR_DATA_W'(capacity_setting);
      end else begin
         channel_setting = CH_W'(value);
         want = CSR_DATA_W'(channel_setting);
      end
      setting_count++;
      @(posedge clock);
      read_register(addr, readback);
      if (readback !== want)
         report_mismatch($sformatf("register %h read %h after writing %h", addr, readback, want));
   endtask

   // Change both settings once the block has gone quiet
   task automatic set_fifo_config(input int capacity, input int channels);
      settle_fifo();
      write_register(CAPACITY_ADDR, capacity);
      write_register(CHANNELS_ADDR, channels);
   endtask

   // One run of random traffic under a given setting. Frames stay stored
   // across the setting change, so the change itself is exercised too.
   task automatic run_traffic_phase(input int capacity, input int channels, input int words,
                                    input int push_pct, input bit with_gaps);
      logic [ACTION_W-1:0] action;
      int roll;
      set_fifo_config(capacity, channels);
      repeat (words) begin
         roll = $urandom_range(0, 99);
         if (roll < 3)
            action = ACT_UNUSED;
         else if (roll < 6)
            action = ACT_FLUSH;
         else if ($urandom_range(0, 99) < push_pct)
            action = ACT_PUSH;
         else
            action = ACT_POP;
         // A pop that would read lanes never written is replaced by a flush
         if (action == ACT_POP && pop_hits_unwritten())
            action = ACT_FLUSH;
         send_word(action, random_frame());
         if (with_gaps && $urandom_range(0, 7) == 0)
            pause_sender($urandom_range(1, 15));
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   task automatic test_register_reset_values();
      logic [CSR_DATA_W-1:0] data;
      read_register(CAPACITY_ADDR, data);
      if (data !== CSR_DATA_W'(CAPACITY_RESET))
         report_mismatch($sformatf("capacity reads %h after reset", data));
      read_register(CHANNELS_ADDR, data);
      if (data !== CSR_DATA_W'(CHANNELS_RESET))
         report_mismatch($sformatf("channels reads %h after reset", data));
   endtask

   // Write the extremes and out-of-range values of both registers
   task automatic test_register_access();
      int capacities [5] = '{1, 256, 511, 0, 300};
      int channels   [5] = '{1, 8, 15, 0, 9};
      for (int i = 0; i < 5; i++)
         set_fifo_config(capacities[i], channels[i]);
   endtask

   task automatic test_directed_corners();
      frame_type ones;
      frame_type zeros;
      frame_type stripes;
      ones  = '1;
      zeros = '0;
      for (int i = 0; i < MAX_CHANNELS; i++)
         stripes[i] = i[0] ? 32'h5555_5555 : 32'hAAAA_AAAA;

      // Reset setting: empty pop, extremes, ignored action, flush
      set_fifo_config(256, 2);
      send_word(ACT_POP, zeros);
      send_word(ACT_PUSH, ones);
      send_word(ACT_PUSH, zeros);
      send_word(ACT_UNUSED, ones);
      send_word(ACT_POP, zeros);
      send_word(ACT_POP, ones);
      send_word(ACT_POP, ones);
      send_word(ACT_FLUSH, ones);

      // One-frame buffer, all lanes: the second push drops the first
      set_fifo_config(1, 8);
      send_word(ACT_PUSH, ones);
      send_word(ACT_PUSH, stripes);
      send_word(ACT_POP, zeros);

      // Zero capacity and zero channels act as one
      set_fifo_config(0, 0);
      send_word(ACT_PUSH, random_frame());
      send_word(ACT_PUSH, random_frame());
      send_word(ACT_POP, zeros);

      // Values above the limits clamp to depth and eight lanes
      set_fifo_config(511, 15);
      send_word(ACT_PUSH, random_frame());
      send_word(ACT_POP, zeros);

      // Lower capacity below the stored count: the push drops, the count holds
      set_fifo_config(8, 8);
      repeat (5) send_word(ACT_PUSH, random_frame());
      set_fifo_config(2, 8);
      send_word(ACT_PUSH, stripes);
      send_word(ACT_POP, zeros);
      send_word(ACT_FLUSH, zeros);
   endtask

   // Each phase starts by draining, so every outstanding result has come before its settings change
   task automatic test_random_traffic();
      run_traffic_phase(1, 8, 120, 60, 1'b1);
      run_traffic_phase(2, 1, 120, 55, 1'b1);
      run_traffic_phase(256, 8, 330, 88, 1'b1);   // long push-heavy run with capacity at full depth
      run_traffic_phase(3, 4, 150, 50, 1'b1);     // count left above the new capacity
      run_traffic_phase(0, 0, 100, 50, 1'b1);
      run_traffic_phase(511, 15, 150, 40, 1'b1);
      run_traffic_phase($urandom_range(4, 16), $urandom_range(1, 8), 200, 50, 1'b1);
      run_traffic_phase($urandom_range(4, 16), $urandom_range(1, 8), 200, 45, 1'b1);
      run_traffic_phase($urandom_range(1, 32), $urandom_range(1, 8), 200, 60, 1'b1);
   endtask

   // Back-to-back words only, at the full rate of the block
   task automatic test_gapless_tail();
      run_traffic_phase(5, 2, 250, 50, 1'b0);
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_reset_values();
      test_register_access();
      test_directed_corners();
      test_random_traffic();
      test_gapless_tail();

      // Wait for the last results, bounded, then a few more cycles for strays
      start <= 1'b0;
      for (int k = 0; k < 200 && replies_due.size() != 0; k++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (replies_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", replies_due.size()));

      $display("covered %0d pushes (%0d dropping the oldest), %0d pops (%0d silent),",
               push_count, drop_count, pop_count, silent_count);
      $display("%0d flushes, %0d ignored words and %0d register writes; %0d mismatches",
               flush_count, ignored_count, setting_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("audio_frame_fifo_drop_oldest_test passed");
      end else begin
         $display("audio_frame_fifo_drop_oldest_test failed");
      end
      $finish;
   end

   // Hard stop far beyond the slowest correct run
   initial begin
      #3_000_000;
      $display("audio_frame_fifo_drop_oldest_test failed");
      $finish;
   end

endmodule
